// ----- rtl/core/samq_pkg.sv -----
`default_nettype none

package samq_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int SUM_W          = 48;
    localparam int CNT_W          = 16;
    localparam int PROD_W         = SAMPLE_W + 4;
    localparam int SETTLE_SAMPLES = 4;
    localparam int DIV_STEPS      = SUM_W;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W      = 3;
    localparam int EVENT_W        = 3;
    localparam int TDATA_W        = 72;

    localparam logic [CNT_W-1:0] CNT_MAX    = '1;
    localparam logic [CNT_W-1:0] SETTLE_CNT = CNT_W'(SETTLE_SAMPLES);
    localparam logic [CNT_W-1:0] FIRST_CNT  = CNT_W'(SETTLE_SAMPLES + 1);

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_LOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_HIGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_ENABLE = 3'd4;

    typedef enum logic [EVENT_W-1:0] {
        EV_IDLE     = 3'd0,
        EV_OUTSIDE  = 3'd1,
        EV_SETTLING = 3'd2,
        EV_REJECTED = 3'd3,
        EV_AVERAGED = 3'd4,
        EV_CLOSED   = 3'd5
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_TEST,
        S_START,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [CNT_W-1:0]        divisor;
    } t_div_req;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- rtl/core/samq_div.sv -----
`default_nettype none

module samq_div (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire samq_pkg::t_div_req i_req,
    output samq_pkg::t_div_rsp  o_rsp
);
    import samq_pkg::*;

    logic                       r_busy, n_busy;
    logic                       r_fin, n_fin;
    logic                       r_done, n_done;
    logic [DIV_CNT_W-1:0]       r_cnt, n_cnt;
    logic                       r_neg, n_neg;
    logic [SUM_W-1:0]           r_mag, n_mag;
    logic [CNT_W-1:0]           r_rem, n_rem;
    logic [CNT_W-1:0]           r_dvs, n_dvs;
    logic signed [SAMPLE_W-1:0] r_quot, n_quot;

    logic [CNT_W:0]             rem_sh;
    logic                       q_bit;
    logic                       too_big;

    always_comb begin
        rem_sh  = {r_rem, r_mag[SUM_W-1]};
        q_bit   = (rem_sh >= {1'b0, r_dvs});
        if (r_neg) begin
            too_big = (r_mag[SUM_W-1:SAMPLE_W] != '0) ||
                      (r_mag[SAMPLE_W-1] && (r_mag[SAMPLE_W-2:0] != '0));
        end else begin
            too_big = (r_mag[SUM_W-1:SAMPLE_W-1] != '0);
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_fin  = 1'b0;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_mag  = r_mag;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quot = r_quot;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_neg  = i_req.dividend[SUM_W-1];
            n_mag  = i_req.dividend[SUM_W-1] ? (SUM_W'(0) - i_req.dividend) : i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = q_bit ? CNT_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[CNT_W-1:0];
            n_mag = {r_mag[SUM_W-2:0], q_bit};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_fin  = 1'b1;
            end
        end else if (r_fin) begin
            n_done = 1'b1;
            if (too_big) begin
                n_quot = r_neg ? SMP_MIN : SMP_MAX;
            end else if (r_neg) begin
                n_quot = SAMPLE_W'(0) - r_mag[SAMPLE_W-1:0];
            end else begin
                n_quot = r_mag[SAMPLE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_fin  <= n_fin;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_neg  <= n_neg;
        r_mag  <= n_mag;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held longer than one cycle");
    a_busy_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_fin) else $error("divider finishing while still stepping");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (!r_busy && !r_fin)) else $error("divider started while busy");

endmodule

`default_nettype wire

// ----- rtl/core/settled_average_measurement_qualifier.sv -----
// Sequence: a request passes S_EVAL and goes to S_DONE when no average is needed;
// closing a measurement adds S_START and S_DIV, forming a running average also S_TEST;
// the 48-step serial divider sets the long cases and a stalled output holds S_DONE.
// Throughput: one request at a time; the next is accepted once the result of the
// previous one has moved into the output register.
// Reset: synchronous, active low; clears configuration, count, sum and last average.
`default_nettype none

module settled_average_measurement_qualifier (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire [samq_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [samq_pkg::SAMPLE_W-1:0]         i_cfg_data,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire [samq_pkg::SAMPLE_W-1:0]         s_axis_tdata,  // sample
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // shown_value, in_limits, first_sample, first_pass, final_average, zero fill
    output logic [samq_pkg::TDATA_W-1:0]         m_axis_tdata,
    output logic [samq_pkg::EVENT_W-1:0]         m_axis_tuser   // event_res
);
    import samq_pkg::*;

    t_state r_state, n_state;

    logic signed [SAMPLE_W-1:0] r_win_lo, n_win_lo;
    logic signed [SAMPLE_W-1:0] r_win_hi, n_win_hi;
    logic signed [SAMPLE_W-1:0] r_pass_lo, n_pass_lo;
    logic signed [SAMPLE_W-1:0] r_pass_hi, n_pass_hi;
    logic                       r_enable, n_enable;

    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic signed [SAMPLE_W-1:0] r_last, n_last;

    logic signed [SAMPLE_W-1:0] r_x, n_x;
    logic signed [PROD_W-1:0]   r_x10, n_x10;
    logic signed [PROD_W-1:0]   r_l11, n_l11;
    logic signed [PROD_W-1:0]   r_l9, n_l9;
    logic                       r_close, n_close;

    t_event                     r_ev, n_ev;
    logic signed [SAMPLE_W-1:0] r_shown, n_shown;
    logic                       r_first, n_first;
    logic                       r_fpass, n_fpass;
    logic signed [SAMPLE_W-1:0] r_fin, n_fin;

    logic                       r_out_valid, n_out_valid;
    t_event                     r_out_ev, n_out_ev;
    logic signed [SAMPLE_W-1:0] r_out_shown, n_out_shown;
    logic                       r_out_inlim, n_out_inlim;
    logic                       r_out_first, n_out_first;
    logic                       r_out_fpass, n_out_fpass;
    logic signed [SAMPLE_W-1:0] r_out_fin, n_out_fin;

    t_div_req                   div_req;
    t_div_rsp                   div_rsp;

    logic                       in_window;
    logic [CNT_W-1:0]           cnt_inc;
    logic                       reject;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [PROD_W-1:0]   x_ext, l_ext;
    logic                       out_free;

    samq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;

    assign div_req.start    = (r_state == S_START);
    assign div_req.dividend = r_sum;
    assign div_req.divisor  = r_cnt - SETTLE_CNT;

    always_comb begin
        in_window = (r_win_lo < r_x) && (r_x < r_win_hi);
        cnt_inc   = (r_cnt != CNT_MAX) ? (r_cnt + 1'b1) : r_cnt;
        x_ext     = PROD_W'(r_x);
        l_ext     = PROD_W'(r_last);
        reject    = (r_last != '0) && ((r_x10 > r_l11) || (r_x10 < r_l9));
        sum_wide  = {r_sum[SUM_W-1], r_sum} + (SUM_W+1)'(r_x);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!r_enable) begin
                    n_state = S_DONE;
                end else if (in_window) begin
                    n_state = (cnt_inc > SETTLE_CNT) ? S_TEST : S_DONE;
                end else begin
                    n_state = (r_cnt > SETTLE_CNT) ? S_START : S_DONE;
                end
            end
            S_TEST: begin
                n_state = reject ? S_DONE : S_START;
            end
            S_START: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_win_lo    = r_win_lo;
        n_win_hi    = r_win_hi;
        n_pass_lo   = r_pass_lo;
        n_pass_hi   = r_pass_hi;
        n_enable    = r_enable;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_last      = r_last;
        n_x         = r_x;
        n_x10       = r_x10;
        n_l11       = r_l11;
        n_l9        = r_l9;
        n_close     = r_close;
        n_ev        = r_ev;
        n_shown     = r_shown;
        n_first     = r_first;
        n_fpass     = r_fpass;
        n_fin       = r_fin;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_ev    = r_out_ev;
        n_out_shown = r_out_shown;
        n_out_inlim = r_out_inlim;
        n_out_first = r_out_first;
        n_out_fpass = r_out_fpass;
        n_out_fin   = r_out_fin;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_x = s_axis_tdata;
                end
            end
            S_EVAL: begin
                n_shown = r_x;
                n_first = 1'b0;
                n_fpass = 1'b0;
                n_fin   = '0;
                n_close = 1'b0;
                n_x10   = (x_ext <<< 3) + (x_ext <<< 1);
                n_l11   = (l_ext <<< 3) + (l_ext <<< 1) + l_ext;
                n_l9    = (l_ext <<< 3) + l_ext;
                if (!r_enable) begin
                    n_ev = EV_IDLE;
                end else if (in_window) begin
                    n_cnt = cnt_inc;
                    n_ev  = EV_SETTLING;
                end else if (r_cnt > SETTLE_CNT) begin
                    n_close = 1'b1;
                end else begin
                    n_ev   = EV_OUTSIDE;
                    n_cnt  = '0;
                    n_sum  = '0;
                    n_last = '0;
                end
            end
            S_TEST: begin
                if (reject) begin
                    n_cnt = r_cnt - 1'b1;
                    n_ev  = EV_REJECTED;
                end else begin
                    n_first = (r_cnt == FIRST_CNT);
                    n_fpass = (r_cnt == FIRST_CNT) && (r_pass_lo < r_x) && (r_x < r_pass_hi);
                    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
                        n_sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
                    end else begin
                        n_sum = sum_wide[SUM_W-1:0];
                    end
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (r_close) begin
                        n_ev   = (div_rsp.quot != '0) ? EV_CLOSED : EV_OUTSIDE;
                        n_fin  = div_rsp.quot;
                        n_cnt  = '0;
                        n_sum  = '0;
                        n_last = '0;
                    end else begin
                        n_ev    = EV_AVERAGED;
                        n_shown = div_rsp.quot;
                        n_last  = div_rsp.quot;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_ev    = r_ev;
                    n_out_shown = r_shown;
                    n_out_inlim = (r_pass_lo < r_shown) && (r_shown < r_pass_hi);
                    n_out_first = r_first;
                    n_out_fpass = r_fpass;
                    n_out_fin   = r_fin;
                end
            end
            default: begin
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_LOW: begin
                    n_win_lo = i_cfg_data;
                    n_cnt    = '0;
                end
                REG_WINDOW_HIGH: begin
                    n_win_hi = i_cfg_data;
                    n_cnt    = '0;
                end
                REG_PASS_LOW: begin
                    n_pass_lo = i_cfg_data;
                    n_cnt     = '0;
                end
                REG_PASS_HIGH: begin
                    n_pass_hi = i_cfg_data;
                    n_cnt     = '0;
                end
                REG_MEASURE_ENABLE: begin
                    n_enable = i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win_lo    <= '0;
            r_win_hi    <= '0;
            r_pass_lo   <= '0;
            r_pass_hi   <= '0;
            r_enable    <= 1'b0;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_last      <= '0;
            r_close     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_win_lo    <= n_win_lo;
            r_win_hi    <= n_win_hi;
            r_pass_lo   <= n_pass_lo;
            r_pass_hi   <= n_pass_hi;
            r_enable    <= n_enable;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_last      <= n_last;
            r_close     <= n_close;
            r_out_valid <= n_out_valid;
        end
        r_x         <= n_x;
        r_x10       <= n_x10;
        r_l11       <= n_l11;
        r_l9        <= n_l9;
        r_ev        <= n_ev;
        r_shown     <= n_shown;
        r_first     <= n_first;
        r_fpass     <= n_fpass;
        r_fin       <= n_fin;
        r_out_ev    <= n_out_ev;
        r_out_shown <= n_out_shown;
        r_out_inlim <= n_out_inlim;
        r_out_first <= n_out_first;
        r_out_fpass <= n_out_fpass;
        r_out_fin   <= n_out_fin;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_ev;
    assign m_axis_tdata  = {{(TDATA_W - 2*SAMPLE_W - 3){1'b0}}, r_out_fin, r_out_fpass,
                            r_out_first, r_out_inlim, r_out_shown};

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready stayed high after a request was taken");
    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV)) else $error("divider finished outside its wait");
    a_first_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_first) |-> (r_out_ev == EV_AVERAGED))
        else $error("first sample flagged on a result that is not an average");

endmodule

`default_nettype wire
